// File: rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// types and constants shared by the breakpoint address table
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int ADDR_BITS_DEF = 21;

	// fixed field widths of the request and result beats, and internal extension widths
	localparam int ADDR_W      = 21;
	localparam int SLOT_W      = 4;
	localparam int ADDR_EXT_W  = 32;
	localparam int IDX_EXT_W   = 8;

	typedef enum logic [1:0] {
		REQ_SET      = 2'd0,
		REQ_CLR_ADDR = 2'd1,
		REQ_CLR_SLOT = 2'd2,
		REQ_CHECK    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [ADDR_W-1:0]  address;
		logic [SLOT_W-1:0]  slot;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot_used;
		logic               hit;
	} rsp_t;

endpackage

// File: rtl/breakpoint_address_table.sv
// ----------------------------------------------------------------------------
// breakpoint_address_table
// associative table of breakpoint addresses with set, clear and check
// ----------------------------------------------------------------------------
// A request beat is taken on every cycle with start high; busy stays low.
// Each request gives exactly one result. The edge that takes a request loads
// the input register, and the result register is loaded from it with done.
// One request per cycle is sustained. All slots are compared in parallel
// against the registered request, and the table is updated at the same edge
// that loads the result, so the next request already sees the change. The
// receiver cannot stall: a result is on the result port for one cycle only.
// ----------------------------------------------------------------------------
module breakpoint_address_table #(
	parameter int SLOTS     = bat_pkg::SLOTS_DEF,
	parameter int ADDR_BITS = bat_pkg::ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bat_pkg::req_t req,
	output logic          done,
	output bat_pkg::rsp_t result
);

	localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                 valid_s1;
	bat_pkg::req_t        req_s1;
	logic                 done_q;
	bat_pkg::rsp_t        result_q;

	logic [bat_pkg::ADDR_EXT_W-1:0] addr_ext;
	logic [ADDR_BITS-1:0] key;
	logic [SLOTS-1:0]     match;
	logic [SLOTS-1:0]     free;
	logic                 match_any;
	logic [IdxW-1:0]      match_idx;
	logic                 free_any;
	logic [IdxW-1:0]      free_idx;
	logic [bat_pkg::IDX_EXT_W-1:0] match_ext;
	logic [bat_pkg::IDX_EXT_W-1:0] free_ext;
	logic [bat_pkg::IDX_EXT_W-1:0] slot_ext;
	logic                 in_range;
	logic [IdxW-1:0]      slot_idx;
	logic                 slot_full;

	bat_pkg::rsp_t        rsp;
	logic                 wr_do;
	logic [IdxW-1:0]      wr_idx;
	logic [ADDR_BITS-1:0] wr_data;
	logic [SLOTS-1:0]     wr_en;
	logic                 accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_s1 <= req;
	end

	assign addr_ext = bat_pkg::ADDR_EXT_W'(req_s1.address);
	assign key      = addr_ext[ADDR_BITS-1:0];

	bat_cells #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_cells (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (key),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.match   (match),
		.free    (free)
	);

	bat_prienc #(
		.N  (SLOTS),
		.IW (IdxW)
	) u_match_enc (
		.vec (match),
		.any (match_any),
		.idx (match_idx)
	);

	bat_prienc #(
		.N  (SLOTS),
		.IW (IdxW)
	) u_free_enc (
		.vec (free),
		.any (free_any),
		.idx (free_idx)
	);

	assign match_ext = bat_pkg::IDX_EXT_W'(match_idx);
	assign free_ext  = bat_pkg::IDX_EXT_W'(free_idx);
	assign slot_ext  = bat_pkg::IDX_EXT_W'(req_s1.slot);
	assign in_range  = (slot_ext < bat_pkg::IDX_EXT_W'(SLOTS));
	assign slot_idx  = IdxW'(req_s1.slot);
	assign slot_full = in_range && !free[slot_idx];

	// request decode
	always_comb begin
		rsp.status    = bat_pkg::ST_OK;
		rsp.slot_used = '0;
		rsp.hit       = 1'b0;
		wr_do         = 1'b0;
		wr_idx        = '0;
		wr_data       = '0;
		unique case (req_s1.req_type)
			bat_pkg::REQ_CLR_SLOT: begin
				rsp.slot_used = req_s1.slot;
				if (!in_range) begin
					rsp.status = bat_pkg::ST_INVALID;
				end else if (!slot_full) begin
					rsp.status = bat_pkg::ST_NOTFOUND;
				end else begin
					wr_do  = 1'b1;
					wr_idx = slot_idx;
				end
			end
			bat_pkg::REQ_SET: begin
				if (key == '0) begin
					rsp.status = bat_pkg::ST_INVALID;
				end else if (match_any) begin
					rsp.status    = bat_pkg::ST_DUP;
					rsp.slot_used = match_ext[bat_pkg::SLOT_W-1:0];
				end else if (!free_any) begin
					rsp.status = bat_pkg::ST_FULL;
				end else begin
					rsp.slot_used = free_ext[bat_pkg::SLOT_W-1:0];
					wr_do         = 1'b1;
					wr_idx        = free_idx;
					wr_data       = key;
				end
			end
			bat_pkg::REQ_CLR_ADDR: begin
				if (key == '0) begin
					rsp.status = bat_pkg::ST_INVALID;
				end else if (!match_any) begin
					rsp.status = bat_pkg::ST_NOTFOUND;
				end else begin
					rsp.slot_used = match_ext[bat_pkg::SLOT_W-1:0];
					wr_do         = 1'b1;
					wr_idx        = match_idx;
				end
			end
			bat_pkg::REQ_CHECK: begin
				if (key == '0) begin
					rsp.status = bat_pkg::ST_INVALID;
				end else if (!match_any) begin
					rsp.status = bat_pkg::ST_NOTFOUND;
				end else begin
					rsp.slot_used = match_ext[bat_pkg::SLOT_W-1:0];
					rsp.hit       = 1'b1;
				end
			end
			default: begin
				rsp.status = bat_pkg::ST_INVALID;
			end
		endcase
	end

	assign wr_en = (valid_s1 && wr_do) ? (SLOTS'(1) << wr_idx) : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) result_q <= rsp;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/bat_cells.sv
// ----------------------------------------------------------------------------
// bat_cells
// slot registers with a compare lane per slot: address match and free flags
// ----------------------------------------------------------------------------
module bat_cells #(
	parameter int SLOTS     = bat_pkg::SLOTS_DEF,
	parameter int ADDR_BITS = bat_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ADDR_BITS-1:0] key,
	input  logic [SLOTS-1:0]     wr_en,
	input  logic [ADDR_BITS-1:0] wr_data,
	output logic [SLOTS-1:0]     match,
	output logic [SLOTS-1:0]     free
);

	logic [ADDR_BITS-1:0] entry_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) entry_q[i] <= '0;
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (wr_en[i]) entry_q[i] <= wr_data;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (entry_q[i] == key);
			free[i]  = (entry_q[i] == '0);
		end
	end

endmodule

// File: rtl/bat_prienc.sv
// ----------------------------------------------------------------------------
// bat_prienc
// lowest-index priority encoder
// ----------------------------------------------------------------------------
module bat_prienc #(
	parameter int N  = bat_pkg::SLOTS_DEF,
	parameter int IW = 4
) (
	input  logic [N-1:0]  vec,
	output logic          any,
	output logic [IW-1:0] idx
);

	always_comb begin
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (vec[i]) idx = IW'(i);
		end
	end

	assign any = |vec;

endmodule

// File: rtl/bat_checker.sv
// ----------------------------------------------------------------------------
// bat_checker
// port-level checks for the breakpoint address table
// ----------------------------------------------------------------------------
module bat_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input bat_pkg::req_t req,
	input logic          done,
	input bat_pkg::rsp_t result
);

	// every accepted beat gives a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted beat gave no result");

	// no result without an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result without a request");

	// a hit only with status ok on a check of a nonzero address
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.address == '0) |=> ##1 (!result.hit))
		else $error("hit on address zero");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.status == bat_pkg::ST_OK))
		else $error("hit with a non-ok status");

	// full table reports no slot and no hit
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == bat_pkg::ST_FULL) |->
		(result.slot_used == '0 && !result.hit))
		else $error("full status with slot or hit set");

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);

// File: dv/breakpoint_address_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_address_table_tb
// self-checking bench for the breakpoint address table
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge and taken when start is high and
// busy is low. Each taken beat is run through a behavioral copy of the table
// that yields the expected result and updates its own slots. Every result
// beat is compared field by field with the oldest expected one. A directed
// pass fills the table and walks the corner cases, then random traffic over
// a small address pool keeps the table near full, in several idle phases.
// ----------------------------------------------------------------------------
module breakpoint_address_table_tb;

	localparam int N_SLOTS   = bat_pkg::SLOTS_DEF;
	localparam int POOL_SIZE = 24;
	localparam logic [bat_pkg::ADDR_W-1:0] ADDR_MAX = '1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	bat_pkg::req_t req;
	bat_pkg::rsp_t result;

	logic [bat_pkg::ADDR_W-1:0] bp_slots [N_SLOTS];
	logic [bat_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
	bat_pkg::rsp_t     pending_rsp [$];
	int                beats_taken;
	int                results_seen;
	int                fail_count;
	int                idle_pct;
	int                status_seen [5];

	breakpoint_address_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// lowest slot holding the address; address zero finds the lowest free slot
	function automatic int find_slot(input logic [bat_pkg::ADDR_W-1:0] addr);
		for (int i = 0; i < N_SLOTS; i++) begin
			if (bp_slots[i] == addr) return i;
		end
		return -1;
	endfunction

	function automatic bat_pkg::rsp_t apply_request(input bat_pkg::req_t r);
		bat_pkg::rsp_t e;
		int k;
		e.status    = bat_pkg::ST_OK;
		e.slot_used = '0;
		e.hit       = 1'b0;
		if (r.req_type == bat_pkg::REQ_CLR_SLOT) begin
			e.slot_used = r.slot;
			if (int'(r.slot) >= N_SLOTS) begin
				e.status = bat_pkg::ST_INVALID;
			end else if (bp_slots[r.slot] == '0) begin
				e.status = bat_pkg::ST_NOTFOUND;
			end else begin
				bp_slots[r.slot] = '0;
			end
		end else if (r.address == '0) begin
			e.status = bat_pkg::ST_INVALID;
		end else if (r.req_type == bat_pkg::REQ_SET) begin
			k = find_slot(r.address);
			if (k >= 0) begin
				e.status    = bat_pkg::ST_DUP;
				e.slot_used = bat_pkg::SLOT_W'(k);
			end else begin
				k = find_slot('0);
				if (k < 0) begin
					e.status = bat_pkg::ST_FULL;
				end else begin
					bp_slots[k] = r.address;
					e.slot_used = bat_pkg::SLOT_W'(k);
				end
			end
		end else begin
			k = find_slot(r.address);
			if (k < 0) begin
				e.status = bat_pkg::ST_NOTFOUND;
			end else begin
				e.slot_used = bat_pkg::SLOT_W'(k);
				if (r.req_type == bat_pkg::REQ_CLR_ADDR) bp_slots[k] = '0;
				else e.hit = 1'b1;
			end
		end
		return e;
	endfunction

	// result check first, then predict the beat taken at this edge
	always @(posedge clk) begin
		bat_pkg::rsp_t e;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (int'(result.status) < 5) status_seen[int'(result.status)]++;
				if (pending_rsp.size() == 0) begin
					$display("%0t: result beat with nothing expected, got status %0d slot %0d hit %0d",
						$time, result.status, result.slot_used, result.hit);
					fail_count++;
				end else begin
					e = pending_rsp.pop_front();
					if (result.status !== e.status) begin
						$display("%0t: status mismatch, expected %0d got %0d",
							$time, e.status, result.status);
						fail_count++;
					end
					if (result.slot_used !== e.slot_used) begin
						$display("%0t: slot_used mismatch, expected %0d got %0d",
							$time, e.slot_used, result.slot_used);
						fail_count++;
					end
					if (result.hit !== e.hit) begin
						$display("%0t: hit mismatch, expected %0d got %0d",
							$time, e.hit, result.hit);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				pending_rsp.push_back(apply_request(req));
				beats_taken++;
			end
		end
	end

	function automatic bat_pkg::req_t make_req(input bat_pkg::req_type_t t,
		input logic [bat_pkg::ADDR_W-1:0] a, input logic [bat_pkg::SLOT_W-1:0] s);
		bat_pkg::req_t r;
		r.req_type = t;
		r.address  = a;
		r.slot     = s;
		return r;
	endfunction

	// called on a falling edge, returns on the falling edge after the beat is taken
	task automatic send_beat(input bat_pkg::req_t r);
		int n;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		n = beats_taken;
		start <= 1'b1;
		req   <= r;
		while (beats_taken == n) @(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [bat_pkg::ADDR_W-1:0] a;
		idle_pct = 0;
		send_beat(make_req(bat_pkg::REQ_CHECK, 21'h5, '0));
		// fill every slot
		for (int i = 0; i < N_SLOTS; i++) begin
			if (i == 0) a = 21'h1;
			else if (i == 1) a = 21'h0AAAAA;
			else if (i == 2) a = 21'h155555;
			else if (i == N_SLOTS - 1) a = ADDR_MAX;
			else a = bat_pkg::ADDR_W'(21'h0A5A5 + i * 21'h11111);
			send_beat(make_req(bat_pkg::REQ_SET, a, bat_pkg::SLOT_W'(i)));
		end
		send_beat(make_req(bat_pkg::REQ_SET, 21'h1234, '0));
		send_beat(make_req(bat_pkg::REQ_SET, 21'h1, '0));
		send_beat(make_req(bat_pkg::REQ_SET, '0, '1));
		send_beat(make_req(bat_pkg::REQ_CLR_ADDR, '0, '0));
		send_beat(make_req(bat_pkg::REQ_CHECK, '0, '0));
		send_beat(make_req(bat_pkg::REQ_CHECK, ADDR_MAX, '0));
		send_beat(make_req(bat_pkg::REQ_CHECK, 21'h1234, '0));
		send_beat(make_req(bat_pkg::REQ_CLR_ADDR, 21'h155555, '0));
		send_beat(make_req(bat_pkg::REQ_CLR_SLOT, '1, 4'd5));
		send_beat(make_req(bat_pkg::REQ_CLR_SLOT, '0, 4'd5));
		send_beat(make_req(bat_pkg::REQ_CLR_ADDR, 21'h155555, '0));
		send_beat(make_req(bat_pkg::REQ_SET, 21'h1234, '0));
		send_beat(make_req(bat_pkg::REQ_CLR_SLOT, ADDR_MAX, 4'd15));
		drain();
	endtask

	function automatic bat_pkg::req_t random_beat();
		bat_pkg::req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) r.req_type = bat_pkg::REQ_SET;
		else if (pick < 55) r.req_type = bat_pkg::REQ_CLR_ADDR;
		else if (pick < 70) r.req_type = bat_pkg::REQ_CLR_SLOT;
		else r.req_type = bat_pkg::REQ_CHECK;
		r.slot = bat_pkg::SLOT_W'($urandom_range(N_SLOTS - 1));
		if ($urandom_range(99) < 85) r.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
		else if ($urandom_range(1) == 0) r.address = '0;
		else r.address = bat_pkg::ADDR_W'($urandom_range(0, int'(ADDR_MAX)));
		return r;
	endfunction

	// pool is a bit larger than the table so it fills, overflows and frees
	task automatic test_random(input int pct, input int count);
		idle_pct = pct;
		addr_pool[0] = 21'h1;
		addr_pool[1] = ADDR_MAX;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = bat_pkg::ADDR_W'($urandom_range(1, int'(ADDR_MAX)));
		for (int i = 0; i < count; i++) send_beat(random_beat());
		drain();
	endtask

	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		beats_taken  = 0;
		results_seen = 0;
		fail_count   = 0;
		idle_pct     = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (bp_slots[i]) bp_slots[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(0, 400);
		test_random(54, 400);
		test_random(0, 400);
		test_random(33, 400);

		repeat (10) @(negedge clk);
		$display("covered %0d request beats and %0d result beats over four idle phases",
			beats_taken, results_seen);
		$display("status counts: ok %0d, dup %0d, full %0d, not found %0d, invalid %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending_rsp.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
